// ===== rtl/ir_pulse_space_capture_assert.svh =====
// assertion macros shared by the capture block rtl
`ifndef IR_PULSE_SPACE_CAPTURE_ASSERT_SVH
`define IR_PULSE_SPACE_CAPTURE_ASSERT_SVH

// same-cycle implication, off while reset is asserted
`define IRPSC_ASSERT_SAME(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("irpsc same-cycle check failed");

// next-cycle implication, off while reset is asserted
`define IRPSC_ASSERT_NEXT(label, ck, rn, ante, cons) \
	label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("irpsc next-cycle check failed");

`endif

// ===== rtl/irpsc_pkg.sv =====
// types, constants and helpers for the ir pulse/space capture block
package irpsc_pkg;

	localparam int DURATION_BITS = 24;
	localparam int SEC_W         = 31;
	localparam int US_W          = 20;
	localparam int LIMIT_W       = 24;
	localparam int SEL_W         = 2;
	localparam int CFG_IDX_W     = 2;

	localparam int S_TDATA_W = ((SEC_W + US_W + 1 + 7) / 8) * 8;
	localparam int M_TDATA_W = ((DURATION_BITS + 7) / 8) * 8;
	localparam int CMP_W     = (DURATION_BITS > LIMIT_W) ? DURATION_BITS : LIMIT_W;

	localparam int GAP_SECONDS = 15;
	localparam int US_PER_S    = 1000000;
	// product of up to fifteen seconds in microseconds
	localparam int PROD_W      = 24;
	// signed microsecond difference, wider than the product and timestamp fields
	localparam int DIFF_W      = 34;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [DURATION_BITS-1:0] MAXD = '1;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_EDGE  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_POLARITY_SELECT  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLITCH_LIMIT     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_SPACE_LIMIT = 2'd2;

	localparam logic [SEL_W-1:0]   POLARITY_SELECT_RST  = 2'd2;
	localparam logic [LIMIT_W-1:0] GLITCH_LIMIT_RST     = 24'd250;
	localparam logic [LIMIT_W-1:0] LONG_SPACE_LIMIT_RST = 24'd20000;

	typedef logic [DURATION_BITS-1:0] dur_t;

	// one measured interval, front to back
	typedef struct packed {
		dur_t dur;
		logic pulse;
	} qword_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] glitch_limit;
		logic [LIMIT_W-1:0] long_space_limit;
	} cfg_t;

	function automatic dur_t sat_add(input dur_t a, input dur_t b);
		logic [DURATION_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[DURATION_BITS] ? MAXD : s[DURATION_BITS-1:0];
	endfunction

	function automatic logic above(input dur_t d, input logic [LIMIT_W-1:0] lim);
		return CMP_W'(d) > CMP_W'(lim);
	endfunction

endpackage

// ===== rtl/irpsc_front.sv =====
// front end: timestamps, polarity and duration measurement per edge
`include "ir_pulse_space_capture_assert.svh"

module irpsc_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic                              in_kind,
	input  logic [irpsc_pkg::SEC_W-1:0]       in_sec,
	input  logic [irpsc_pkg::US_W-1:0]        in_us,
	input  logic                              in_pin,
	input  logic [irpsc_pkg::SEL_W-1:0]       polarity_select,
	input  logic                              q_full,
	output logic                              q_push,
	output irpsc_pkg::qword_t                 q_word
);
	import irpsc_pkg::*;

	logic [SEC_W-1:0]        last_sec_q;
	logic [US_W-1:0]         last_us_q;
	logic                    pol_q;
	logic                    known_q;

	logic                    accept;
	logic signed [SEC_W:0]   dsec;
	logic                    gap;
	logic                    backwards;
	logic [PROD_W-1:0]       prod;
	logic signed [DIFF_W-1:0] diff;
	logic                    pol_eff;
	dur_t                    d;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		dsec      = $signed({1'b0, in_sec}) - $signed({1'b0, last_sec_q});
		gap       = dsec > $signed((SEC_W+1)'(GAP_SECONDS));
		backwards = (in_sec < last_sec_q) || ((in_sec == last_sec_q) && (in_us < last_us_q));
		// only used when the second difference is within 0..15
		prod      = PROD_W'(dsec[3:0]) * PROD_W'(US_PER_S);
		diff      = $signed(DIFF_W'(prod)) + $signed(DIFF_W'(in_us))
			- $signed(DIFF_W'(last_us_q));
		if (gap) begin
			d = MAXD;
		end else if (diff[DIFF_W-1]) begin
			d = '0;
		end else if (diff[DIFF_W-2:0] > (DIFF_W-1)'(MAXD)) begin
			d = MAXD;
		end else begin
			d = diff[DURATION_BITS-1:0];
		end
		if (backwards) begin
			d = MAXD;
		end
		// a long gap seen where a pulse would end means the polarity was wrong
		pol_eff = (gap && (in_pin == pol_q)) ? !pol_q : pol_q;
	end

	assign q_push       = accept && (in_kind == KIND_EDGE) && known_q;
	assign q_word.dur   = d;
	assign q_word.pulse = (in_pin == pol_eff);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			known_q <= 1'b0;
			pol_q   <= 1'b0;
		end else if (accept) begin
			if (in_kind == KIND_START) begin
				known_q <= 1'b1;
				pol_q   <= polarity_select[1] ? in_pin : polarity_select[0];
			end else if (known_q) begin
				pol_q <= pol_eff;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ((in_kind == KIND_START) || known_q)) begin
			last_sec_q <= in_sec;
			last_us_q  <= in_us;
		end
	end

	`IRPSC_ASSERT_SAME(a_no_edge_before_start, clk, arst_n,
		in_valid && in_ready && (in_kind == KIND_EDGE) && !known_q, !q_push)

endmodule

// ===== rtl/irpsc_queue.sv =====
// short queue of measured intervals between front and back
`include "ir_pulse_space_capture_assert.svh"

module irpsc_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  irpsc_pkg::qword_t push_word,
	output logic              full,
	input  logic              pop,
	output logic              not_empty,
	output irpsc_pkg::qword_t head
);
	import irpsc_pkg::*;

	qword_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_q;
	logic [QPTR_W-1:0]   rd_q;
	logic [QCNT_W-1:0]   cnt_q;

	assign full      = cnt_q == QCNT_W'(QDEPTH);
	assign not_empty = cnt_q != '0;
	assign head      = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_word;
		end
	end

	`IRPSC_ASSERT_SAME(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= QCNT_W'(QDEPTH))
	`IRPSC_ASSERT_SAME(a_pop_nonempty, clk, arst_n, pop, cnt_q != '0)
	`IRPSC_ASSERT_SAME(a_push_not_full, clk, arst_n, push, !full)

endmodule

// ===== rtl/irpsc_back.sv =====
// back end: glitch filter and output word sequencer
`include "ir_pulse_space_capture_assert.svh"

module irpsc_back (
	input  logic              clk,
	input  logic              arst_n,
	input  irpsc_pkg::cfg_t   cfg,
	input  logic              q_valid,
	input  irpsc_pkg::qword_t q_word,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output irpsc_pkg::dur_t   out_dur,
	output logic              out_pulse,
	output logic              out_last
);
	import irpsc_pkg::*;

	logic        holding_q;
	dur_t        hs_q;
	dur_t        hp_q;
	qword_t      res_q [3];
	logic [1:0]  cnt_q;
	logic [1:0]  idx_q;

	logic        last_idx;
	logic        out_hs;
	logic        free;
	dur_t        hp_sum;
	dur_t        hs_merge;
	logic        holding_nxt;
	dur_t        hs_nxt;
	dur_t        hp_nxt;
	logic [1:0]  n;
	qword_t      r0;
	qword_t      r1;
	qword_t      r2;

	assign out_valid = cnt_q != 2'd0;
	assign last_idx  = idx_q == (cnt_q - 2'd1);
	assign out_hs    = out_valid && out_ready;
	assign free      = !out_valid || (out_hs && last_idx);
	assign q_pop     = q_valid && free;

	assign out_dur   = res_q[idx_q].dur;
	assign out_pulse = res_q[idx_q].pulse;
	assign out_last  = last_idx;

	always_comb begin
		hp_sum      = sat_add(hp_q, q_word.dur);
		hs_merge    = sat_add(sat_add(hs_q, hp_q), q_word.dur);
		holding_nxt = holding_q;
		hs_nxt      = hs_q;
		hp_nxt      = hp_q;
		n           = 2'd0;
		r0          = q_word;
		r1          = '{dur: '0, pulse: 1'b1};
		r2          = q_word;
		if (holding_q && q_word.pulse) begin
			// glitch pulses pile up until they pass the limit
			if (above(hp_sum, cfg.glitch_limit)) begin
				n           = 2'd2;
				r0          = '{dur: hs_q, pulse: 1'b0};
				r1          = '{dur: hp_sum, pulse: 1'b1};
				holding_nxt = 1'b0;
				hp_nxt      = '0;
			end else begin
				hp_nxt = hp_sum;
			end
		end else if (q_word.pulse) begin
			n = 2'd1;
		end else if (!holding_q) begin
			if (above(q_word.dur, cfg.long_space_limit)) begin
				hs_nxt      = q_word.dur;
				holding_nxt = 1'b1;
			end else begin
				n = 2'd1;
			end
		end else begin
			if (above(q_word.dur, cfg.long_space_limit)) begin
				hs_nxt = hs_merge;
				hp_nxt = '0;
			end else begin
				// release held space and pulse, then this space
				n           = 2'd3;
				r0          = '{dur: hs_q, pulse: 1'b0};
				r1          = '{dur: hp_q, pulse: 1'b1};
				holding_nxt = 1'b0;
				hp_nxt      = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= 1'b0;
			hp_q      <= '0;
			cnt_q     <= 2'd0;
			idx_q     <= 2'd0;
		end else begin
			if (q_pop) begin
				holding_q <= holding_nxt;
				hp_q      <= hp_nxt;
			end
			// a pop only happens once the buffer is empty or its last word leaves
			if (q_pop && (n != 2'd0)) begin
				cnt_q <= n;
				idx_q <= 2'd0;
			end else if (out_hs) begin
				if (last_idx) begin
					cnt_q <= 2'd0;
					idx_q <= 2'd0;
				end else begin
					idx_q <= idx_q + 2'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			hs_q <= hs_nxt;
			if (n != 2'd0) begin
				res_q[0] <= r0;
				res_q[1] <= r1;
				res_q[2] <= r2;
			end
		end
	end

	`IRPSC_ASSERT_SAME(a_idle_pulse_clear, clk, arst_n, !holding_q, hp_q == '0)
	`IRPSC_ASSERT_NEXT(a_stall_holds_word, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(idx_q) && $stable(cnt_q))

endmodule

// ===== rtl/ir_pulse_space_capture.sv =====
// top level of the ir receiver pulse/space capture block
//
// Takes timestamped start and pin-edge words on the slave stream and gives
// pulse/space durations in microseconds on the master stream. The front end
// accepts one input word per clock while the queue is not full: it measures
// the interval since the previous event combinationally and pushes it into a
// two-entry queue. The back end runs the glitch filter on one queued interval
// per cycle while its output buffer is free and loads the zero to three
// resulting words into that buffer, which drains one word per clock while the
// sink is ready, with tlast on the final word of each input. A result is
// registered in the queue and then in the output buffer. The sustained rate
// is one input word per clock while each edge yields at most one result and
// the sink is ready; an edge that releases held filter state gives two or
// three words and occupies the output for each. Configuration writes are
// always ready; the polarity selection takes effect at the next start word.
module ir_pulse_space_capture (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// seconds [30:0], microseconds [50:31], pin_level [51], zero fill
	input  logic [irpsc_pkg::S_TDATA_W-1:0]     s_axis_tdata,
	// kind
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// duration
	output logic [irpsc_pkg::M_TDATA_W-1:0]     m_axis_tdata,
	// is_pulse
	output logic                                m_axis_tuser,
	output logic                                m_axis_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [irpsc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [irpsc_pkg::LIMIT_W-1:0]       cfg_data
);
	import irpsc_pkg::*;

	logic [SEL_W-1:0]   polarity_select_q;
	cfg_t               cfg_q;

	logic               q_push;
	logic               q_full;
	logic               q_pop;
	logic               q_not_empty;
	qword_t             push_word;
	qword_t             head;
	dur_t               out_dur;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_select_q      <= POLARITY_SELECT_RST;
			cfg_q.glitch_limit     <= GLITCH_LIMIT_RST;
			cfg_q.long_space_limit <= LONG_SPACE_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_POLARITY_SELECT:  polarity_select_q      <= cfg_data[SEL_W-1:0];
				CFG_GLITCH_LIMIT:     cfg_q.glitch_limit     <= cfg_data;
				CFG_LONG_SPACE_LIMIT: cfg_q.long_space_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	irpsc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_axis_tvalid),
		.in_ready        (s_axis_tready),
		.in_kind         (s_axis_tuser),
		.in_sec          (s_axis_tdata[SEC_W-1:0]),
		.in_us           (s_axis_tdata[SEC_W+US_W-1:SEC_W]),
		.in_pin          (s_axis_tdata[SEC_W+US_W]),
		.polarity_select (polarity_select_q),
		.q_full          (q_full),
		.q_push          (q_push),
		.q_word          (push_word)
	);

	irpsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_word (push_word),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.head      (head)
	);

	irpsc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_valid   (q_not_empty),
		.q_word    (head),
		.q_pop     (q_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_dur   (out_dur),
		.out_pulse (m_axis_tuser),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = M_TDATA_W'(out_dur);

endmodule

// ===== verif/tb.sv =====
// testbench for ir_pulse_space_capture: directed, per-setting and random edge traffic with a self-checking duration predictor
module tb;
	import irpsc_pkg::*;

	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	localparam logic [SEL_W-1:0] SEL_ACTIVE_HIGH = 2'd0;
	localparam logic [SEL_W-1:0] SEL_ACTIVE_LOW  = 2'd1;
	localparam logic [SEL_W-1:0] SEL_LEARN       = 2'd2;
	localparam logic [SEL_W-1:0] SEL_LEARN_ALT   = 2'd3;

	localparam logic [LIMIT_W-1:0] LIMIT_MAX = '1;
	localparam longint DUR_MAX_L   = (longint'(1) << DURATION_BITS) - 1;
	localparam int     SETTLE_CYC  = 16;
	localparam int     IDLE_LIMIT  = 2000;
	localparam int     HOLD_CYC    = 250;
	localparam int     PRINT_CAP   = 40;

	typedef struct {
		dur_t dur;
		logic pulse;
		logic last;
	} duration_word_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    s_axis_tvalid = 1'b0;
	logic                    s_axis_tready;
	logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
	logic                    s_axis_tuser = 1'b0;
	logic                    m_axis_tvalid;
	logic                    m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0]    m_axis_tdata;
	logic                    m_axis_tuser;
	logic                    m_axis_tlast;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [LIMIT_W-1:0]      cfg_data = '0;

	ir_pulse_space_capture i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// predictor copy of registers and capture state
	logic [SEL_W-1:0]   r_sel        = POLARITY_SELECT_RST;
	logic [LIMIT_W-1:0] r_glitch     = GLITCH_LIMIT_RST;
	logic [LIMIT_W-1:0] r_long_space = LONG_SPACE_LIMIT_RST;
	logic [SEC_W-1:0]   m_last_sec   = '0;
	logic [US_W-1:0]    m_last_us    = '0;
	logic               m_polarity   = 1'b0;
	logic               m_pol_known  = 1'b0;
	logic               m_holding    = 1'b0;
	dur_t               m_held_space = '0;
	dur_t               m_held_pulse = '0;

	duration_word_t expected_durations[$];

	// stimulus timeline and bookkeeping
	logic [SEC_W-1:0] now_sec = '0;
	logic [US_W-1:0]  now_us  = '0;
	logic             pin_now = 1'b0;
	bit               src_gaps_on    = 1'b1;
	bit               sink_stalls_on = 1'b1;
	int unsigned      sink_hold_len  = 0;
	int unsigned      events_sent    = 0;
	int unsigned      starts_sent    = 0;
	int unsigned      words_checked  = 0;
	int unsigned      reg_writes     = 0;
	int unsigned      mismatches     = 0;
	int unsigned      idle_cycles    = 0;

	function automatic dur_t add_saturated(input dur_t a, input dur_t b);
		longint s;
		s = longint'({40'd0, a}) + longint'({40'd0, b});
		return (s > DUR_MAX_L) ? MAXD : dur_t'(s);
	endfunction

	function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [LIMIT_W-1:0] val);
		case (idx)
			CFG_POLARITY_SELECT: begin
				r_sel = val[SEL_W-1:0];
			end
			CFG_GLITCH_LIMIT: begin
				r_glitch = val;
			end
			CFG_LONG_SPACE_LIMIT: begin
				r_long_space = val;
			end
			default: begin
			end
		endcase
	endfunction

	// measure the interval since the previous event and run it through the glitch filter
	function automatic void predict_durations(input logic kind, input logic [SEC_W-1:0] sec,
		input logic [US_W-1:0] us, input logic pin);
		longint dsec;
		longint diff;
		dur_t d;
		logic pulse;
		bit held;
		duration_word_t outs[$];
		if (kind == KIND_START) begin
			m_last_sec = sec;
			m_last_us = us;
			m_polarity = r_sel[1] ? pin : r_sel[0];
			m_pol_known = 1'b1;
			return;
		end
		if (!m_pol_known)
			return;
		dsec = longint'({33'd0, sec}) - longint'({33'd0, m_last_sec});
		if (dsec > GAP_SECONDS) begin
			d = MAXD;
			if (pin == m_polarity)
				m_polarity = ~m_polarity;
		end else begin
			diff = dsec * US_PER_S + longint'({44'd0, us}) - longint'({44'd0, m_last_us});
			if (diff < 0)
				d = '0;
			else if (diff > DUR_MAX_L)
				d = MAXD;
			else
				d = dur_t'(diff);
		end
		if (sec < m_last_sec || (sec == m_last_sec && us < m_last_us))
			d = MAXD;
		m_last_sec = sec;
		m_last_us = us;
		pulse = (pin == m_polarity);
		held = 1'b0;
		if (m_holding && pulse) begin
			m_held_pulse = add_saturated(m_held_pulse, d);
			if (m_held_pulse > r_glitch) begin
				outs.push_back('{m_held_space, 1'b0, 1'b0});
				outs.push_back('{m_held_pulse, 1'b1, 1'b0});
				m_holding = 1'b0;
				m_held_pulse = '0;
			end
		end else begin
			if (!pulse) begin
				if (!m_holding) begin
					if (d > r_long_space) begin
						m_held_space = d;
						m_holding = 1'b1;
						held = 1'b1;
					end
				end else if (d > r_long_space) begin
					// long space while holding: fold glitch pulse and space into the hold
					m_held_space = add_saturated(add_saturated(m_held_space, m_held_pulse), d);
					m_held_pulse = '0;
					held = 1'b1;
				end else begin
					outs.push_back('{m_held_space, 1'b0, 1'b0});
					outs.push_back('{m_held_pulse, 1'b1, 1'b0});
					m_holding = 1'b0;
					m_held_pulse = '0;
				end
			end
			if (!held)
				outs.push_back('{d, pulse, 1'b0});
		end
		if (outs.size() > 0)
			outs[outs.size()-1].last = 1'b1;
		foreach (outs[i])
			expected_durations.push_back(outs[i]);
	endfunction

	function automatic void step_clock(input longint dt);
		longint total;
		total = longint'({44'd0, now_us}) + dt;
		now_sec = now_sec + SEC_W'(total / US_PER_S);
		now_us = US_W'(total % US_PER_S);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("mismatch at word %0d: %s got %0h expected %0h", words_checked, what,
				got, want);
	endtask

	// send one event word and predict what it causes once accepted
	task automatic event_at(input logic kind, input logic [SEC_W-1:0] sec,
		input logic [US_W-1:0] us, input logic pin);
		logic [S_TDATA_W-1:0] word;
		int unsigned gap;
		word = '0;
		word[SEC_W-1:0] = sec;
		word[SEC_W+US_W-1:SEC_W] = us;
		word[SEC_W+US_W] = pin;
		@(negedge clk);
		if (src_gaps_on && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			gap = $urandom_range(1, 14);
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= kind;
		s_axis_tdata <= word;
		do @(posedge clk); while (!s_axis_tready);
		predict_durations(kind, sec, us, pin);
		now_sec = sec;
		now_us = us;
		pin_now = pin;
		events_sent++;
		if (kind == KIND_START)
			starts_sent++;
	endtask

	task automatic edge_after(input longint dt, input logic pin);
		step_clock(dt);
		event_at(KIND_EDGE, now_sec, now_us, pin);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		apply_reg(idx, val);
		reg_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// stop offering words and wait until every predicted word has come out
	task automatic settle_block();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (expected_durations.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic configure(input logic [SEL_W-1:0] sel, input logic [LIMIT_W-1:0] glitch,
		input logic [LIMIT_W-1:0] long_space);
		settle_block();
		// upper bits of the polarity word are don't-care
		write_reg(CFG_POLARITY_SELECT, {22'($urandom), sel});
		write_reg(CFG_GLITCH_LIMIT, glitch);
		write_reg(CFG_LONG_SPACE_LIMIT, long_space);
	endtask

	task automatic random_event();
		int unsigned pick;
		int unsigned shape;
		longint dt;
		longint hi;
		logic pin;
		pick = $urandom_range(0, 99);
		pin = ($urandom_range(0, 9) == 0) ? pin_now : ~pin_now;
		if (pick < 5) begin
			step_clock($urandom_range(0, 50000));
			event_at(KIND_START, now_sec, now_us, 1'($urandom));
		end else if (pick < 8) begin
			event_at(1'($urandom), SEC_W'($urandom), US_W'($urandom), 1'($urandom));
		end else if (pick < 11) begin
			event_at(KIND_EDGE, now_sec - SEC_W'($urandom_range(0, 2)),
				US_W'($urandom_range(0, 999999)), pin);
		end else if (pick < 14) begin
			edge_after(longint'($urandom_range(15, 60)) * US_PER_S
				+ $urandom_range(0, 999999), pin);
		end else if (pick < 17) begin
			event_at(KIND_EDGE, now_sec + SEC_W'($urandom_range(0, 1)),
				US_W'($urandom_range(1000000, 20'hFFFFF)), pin);
		end else begin
			shape = $urandom_range(0, 99);
			if (shape < 40) begin
				dt = $urandom_range(100, 2000);
			end else if (shape < 60) begin
				hi = longint'({40'd0, r_glitch}) * 2 + 1;
				dt = $urandom_range(0, 32'((hi > 20000000) ? 20000000 : hi));
			end else if (shape < 85) begin
				hi = longint'({40'd0, r_long_space}) * 2 + 1;
				dt = $urandom_range(32'(r_long_space / 2),
					32'((hi > 20000000) ? 20000000 : hi));
			end else begin
				dt = $urandom_range(0, 15999999);
			end
			edge_after(dt, pin);
		end
	endtask

	task automatic test_directed_cases();
		event_at(KIND_EDGE, 31'd5, 20'd0, 1'b1);
		event_at(KIND_START, 31'd10, 20'd0, 1'b1);
		edge_after(560, 1'b0);
		edge_after(600, 1'b1);
		edge_after(30000, 1'b0);
		edge_after(100, 1'b1);
		edge_after(25000, 1'b0);
		edge_after(300, 1'b1);
		edge_after(40000, 1'b0);
		edge_after(50, 1'b1);
		edge_after(700, 1'b0);
		edge_after(600, 1'b1);
		// two gaps past fifteen seconds, the first one during a pulse, then one of exactly fifteen
		edge_after(20000000, 1'b1);
		edge_after(20000000, 1'b0);
		edge_after(15000000, 1'b1);
		event_at(KIND_EDGE, now_sec - 31'd3, now_us, 1'b0);
		event_at(KIND_EDGE, now_sec, now_us, 1'b1);
		event_at(KIND_EDGE, now_sec, 20'hFFFFF, 1'b0);
		event_at(KIND_EDGE, now_sec + 31'd1, 20'd0, 1'b1);
		event_at(KIND_START, 31'h7FFFFFFF, 20'd999999, 1'b0);
		event_at(KIND_EDGE, 31'd0, 20'd0, 1'b1);
		edge_after(300, 1'b0);
		edge_after(900, 1'b1);
		edge_after(450, 1'b0);
	endtask

	task automatic test_register_settings();
		configure(SEL_ACTIVE_HIGH, '0, '0);
		event_at(KIND_START, now_sec + 31'd1, now_us, 1'($urandom));
		repeat (35) random_event();
		configure(SEL_ACTIVE_LOW, LIMIT_MAX, LIMIT_MAX);
		event_at(KIND_START, now_sec + 31'd1, now_us, 1'($urandom));
		repeat (35) random_event();
		configure(SEL_LEARN_ALT, 24'($urandom_range(0, 2000)), 24'($urandom_range(0, 60000)));
		event_at(KIND_START, now_sec + 31'd1, now_us, 1'($urandom));
		repeat (35) random_event();
		settle_block();
		write_reg(CFG_UNUSED, 24'($urandom));
		configure(SEL_LEARN, GLITCH_LIMIT_RST, LONG_SPACE_LIMIT_RST);
		event_at(KIND_START, now_sec + 31'd1, now_us, 1'($urandom));
		repeat (35) random_event();
	endtask

	task automatic test_output_hold();
		src_gaps_on = 1'b0;
		sink_hold_len = HOLD_CYC;
		repeat (30) edge_after($urandom_range(200, 1500), ~pin_now);
		src_gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < 320; i++) begin
			if (i >= 240) begin
				src_gaps_on = 1'b0;
				sink_stalls_on = 1'b0;
			end else if (i % 60 == 0) begin
				src_gaps_on = (i % 120 == 0);
				sink_stalls_on = (i % 120 == 0);
			end
			random_event();
		end
	endtask

	initial begin : sink
		int unsigned span;
		forever begin
			@(negedge clk);
			if (sink_hold_len > 0) begin
				m_axis_tready <= 1'b0;
				span = sink_hold_len;
				sink_hold_len = 0;
			end else if (sink_stalls_on && $urandom_range(0, 2) == 0) begin
				m_axis_tready <= 1'b0;
				span = $urandom_range(1, 14);
			end else begin
				m_axis_tready <= 1'b1;
				span = sink_stalls_on ? $urandom_range(1, 12) : 1;
			end
			repeat (span - 1) @(negedge clk);
		end
	end

	always @(posedge clk) begin : check_words
		duration_word_t w;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_durations.size() == 0) begin
				report_mismatch("word with nothing pending, duration",
					longint'(m_axis_tdata), 0);
			end else begin
				w = expected_durations.pop_front();
				if (m_axis_tdata[DURATION_BITS-1:0] !== w.dur)
					report_mismatch("duration", longint'(m_axis_tdata[DURATION_BITS-1:0]),
						longint'(w.dur));
				if (m_axis_tuser !== w.pulse)
					report_mismatch("is_pulse", longint'(m_axis_tuser), longint'(w.pulse));
				if (m_axis_tlast !== w.last)
					report_mismatch("last", longint'(m_axis_tlast), longint'(w.last));
			end
			words_checked++;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
				$display("** ir_pulse_space_capture: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed_cases();
		test_register_settings();
		test_output_hold();
		test_random_traffic();
		settle_block();
		$display("run: %0d events (%0d starts), %0d duration words checked, %0d register writes",
			events_sent, starts_sent, words_checked, reg_writes);
		$display("run: four filter settings, a %0d-cycle output hold, %0d mismatches",
			HOLD_CYC, mismatches);
		if (mismatches == 0)
			$display("** ir_pulse_space_capture: PASSED **");
		else
			$display("** ir_pulse_space_capture: FAILED **");
		$finish;
	end

endmodule
